/* rtl/core/prrs_pkg.sv */
// Shared widths, codes and types of the priority round-robin scheduler.
`default_nettype none

package prrs_pkg;

  localparam int ID_W    = 8;
  localparam int PRIO_W  = 4;
  localparam int REM_W   = 16;
  localparam int STAMP_W = 16;
  localparam int Q_W     = 8;
  localparam int RUN_W   = 8;
  localparam int STAT_W  = 2;

  localparam logic OP_ADD      = 1'b0;
  localparam logic OP_DISPATCH = 1'b1;

  localparam logic [STAT_W-1:0] STAT_ADDED      = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL       = 2'd1;
  localparam logic [STAT_W-1:0] STAT_DISPATCHED = 2'd2;
  localparam logic [STAT_W-1:0] STAT_IDLE       = 2'd3;

  localparam logic [Q_W-1:0]     QUANTUM_RST = 8'd10;
  localparam logic [STAMP_W-1:0] STAMP_LAST  = 16'hFFFF;

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [PRIO_W-1:0]  prio;
    logic [REM_W-1:0]   remaining;
    logic [STAMP_W-1:0] stamp;
  } entry_t;

  typedef struct packed {
    logic load;
    logic scan_start;
    logic commit;
  } dp_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

/* rtl/core/prrs_ifs.sv */
// Channel interfaces of the priority round-robin scheduler.
`default_nettype none

interface prrs_in_if import prrs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              op;
  logic [ID_W-1:0]   task_id;
  logic [PRIO_W-1:0] task_priority;
  logic [REM_W-1:0]  burst_length;

  modport source (output valid, op, task_id, task_priority, burst_length, input ready);
  modport sink   (input valid, op, task_id, task_priority, burst_length, output ready);
endinterface

interface prrs_out_if import prrs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [ID_W-1:0]   run_task;
  logic [RUN_W-1:0]  run_length;
  logic              finished;

  modport source (output valid, status, run_task, run_length, finished, input ready);
  modport sink   (input valid, status, run_task, run_length, finished, output ready);
endinterface

interface prrs_cfg_if import prrs_pkg::*; ();
  logic           valid;
  logic           ready;
  logic [Q_W-1:0] quantum;

  modport source (output valid, quantum, input ready);
  modport sink   (input valid, quantum, output ready);
endinterface

`default_nettype wire

/* rtl/core/prrs_ctrl.sv */
// Controller state machine: accept, table walk, commit.
`default_nettype none

module prrs_ctrl import prrs_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  output dp_cmd_t       cmd,
  input  wire dp_stat_t stat
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_COMMIT = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  assign in_ready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt      = state_r;
    cmd            = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load       = 1'b1;
          cmd.scan_start = 1'b1;
          state_nxt      = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (stat.scan_done) begin
          state_nxt = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        // hold until the result register can take the item
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/core/prrs_dp.sv */
// Datapath: task memory, valid bits, table walk, slot update and result register.
`default_nettype none

module prrs_dp import prrs_pkg::*; #(
  parameter int TASK_SLOTS = 16
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire dp_cmd_t           cmd,
  output dp_stat_t               stat,
  input  wire logic              in_op,
  input  wire logic [ID_W-1:0]   in_task_id,
  input  wire logic [PRIO_W-1:0] in_task_priority,
  input  wire logic [REM_W-1:0]  in_burst_length,
  input  wire logic              cfg_valid,
  input  wire logic [Q_W-1:0]    cfg_quantum,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [STAT_W-1:0]      out_status,
  output logic [ID_W-1:0]        out_run_task,
  output logic [RUN_W-1:0]       out_run_length,
  output logic                   out_finished
);

  localparam int SW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam int CW = $clog2(TASK_SLOTS + 1);
  localparam logic [CW-1:0] CNT_END = CW'(TASK_SLOTS);

  // slot storage
  entry_t                  mem [TASK_SLOTS];
  logic [TASK_SLOTS-1:0]   slot_valid_r;

  // latched item
  logic              op_r;
  logic [ID_W-1:0]   id_r;
  logic [PRIO_W-1:0] prio_r;
  logic [REM_W-1:0]  burst_r;

  // scheduler state
  logic [Q_W-1:0]     quantum_r;
  logic [STAMP_W-1:0] add_cnt_r;
  logic [PRIO_W-1:0]  served_level_r;
  logic [STAMP_W-1:0] last_stamp_r;
  logic               ptr_valid_r;

  // walk
  logic [CW-1:0] cnt_r;
  logic          scanning_r;
  logic          live_r;
  entry_t        rd_r;
  logic          rd_vld_r;
  logic [SW-1:0] rd_idx_r;
  logic          issue;

  // walk results
  logic              any_r;
  logic [PRIO_W-1:0] top_r;
  entry_t            ba_r;
  logic [SW-1:0]     ba_idx_r;
  entry_t            bl_r;
  logic [SW-1:0]     bl_idx_r;
  logic              bl_found_r;
  logic              free_found_r;
  logic [SW-1:0]     free_idx_r;

  // commit
  logic             use_bl;
  entry_t           sel;
  logic [SW-1:0]    sel_idx;
  logic [Q_W-1:0]   q_eff;
  logic [REM_W-1:0] q_ext;
  logic             more;
  logic             can_add;
  logic             wr_en;
  logic [SW-1:0]    wr_addr;
  entry_t           wr_data;
  logic             out_valid_r;

  assign issue          = scanning_r && (cnt_r != CNT_END);
  assign stat.scan_done = scanning_r && (cnt_r == CNT_END) && !live_r;
  assign stat.out_free  = !out_valid_r || out_ready;

  // item and configuration
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= in_op;
      id_r    <= in_task_id;
      prio_r  <= in_task_priority;
      burst_r <= in_burst_length;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quantum_r <= QUANTUM_RST;
    end else if (cfg_valid) begin
      quantum_r <= cfg_quantum;
    end
  end

  // walk control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scanning_r <= 1'b0;
      live_r     <= 1'b0;
      cnt_r      <= '0;
    end else begin
      if (cmd.scan_start) begin
        scanning_r <= 1'b1;
        cnt_r      <= '0;
      end else if (stat.scan_done) begin
        scanning_r <= 1'b0;
      end else if (issue) begin
        cnt_r <= cnt_r + CW'(1);
      end
      live_r <= issue;
    end
  end

  // memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (issue) begin
      rd_r <= mem[cnt_r[SW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_vld_r <= slot_valid_r[cnt_r[SW-1:0]];
      rd_idx_r <= cnt_r[SW-1:0];
    end
  end

  // fold one slot a cycle into top level, best stamps and first free slot
  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      any_r        <= 1'b0;
      bl_found_r   <= 1'b0;
      free_found_r <= 1'b0;
    end else if (live_r) begin
      if (rd_vld_r) begin
        if (!any_r || (rd_r.prio > top_r)) begin
          any_r      <= 1'b1;
          top_r      <= rd_r.prio;
          ba_r       <= rd_r;
          ba_idx_r   <= rd_idx_r;
          bl_r       <= rd_r;
          bl_idx_r   <= rd_idx_r;
          bl_found_r <= (rd_r.stamp < last_stamp_r);
        end else if (rd_r.prio == top_r) begin
          if ((rd_r.stamp < last_stamp_r) && (!bl_found_r || (rd_r.stamp > bl_r.stamp))) begin
            bl_r       <= rd_r;
            bl_idx_r   <= rd_idx_r;
            bl_found_r <= 1'b1;
          end
          if (rd_r.stamp > ba_r.stamp) begin
            ba_r     <= rd_r;
            ba_idx_r <= rd_idx_r;
          end
        end
      end else if (!free_found_r) begin
        free_found_r <= 1'b1;
        free_idx_r   <= rd_idx_r;
      end
    end
  end

  // commit decisions
  always_comb begin
    use_bl  = ptr_valid_r && (served_level_r == top_r) && bl_found_r;
    sel     = use_bl ? bl_r : ba_r;
    sel_idx = use_bl ? bl_idx_r : ba_idx_r;
    q_eff   = (quantum_r == '0) ? Q_W'(1) : quantum_r;
    q_ext   = REM_W'(q_eff);
    more    = sel.remaining > q_ext;
    can_add = free_found_r && (add_cnt_r != STAMP_LAST);

    wr_data = sel;
    wr_data.remaining = sel.remaining - q_ext;
    wr_addr = sel_idx;
    wr_en   = 1'b0;
    if (op_r == OP_ADD) begin
      wr_data.id        = id_r;
      wr_data.prio      = prio_r;
      wr_data.remaining = burst_r;
      wr_data.stamp     = add_cnt_r;
      wr_addr           = free_idx_r;
      wr_en             = cmd.commit && can_add;
    end else begin
      wr_en = cmd.commit && any_r && more;
    end
  end

  // scheduler state update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_valid_r   <= '0;
      add_cnt_r      <= '0;
      served_level_r <= '0;
      last_stamp_r   <= '0;
      ptr_valid_r    <= 1'b0;
    end else if (cmd.commit) begin
      if (op_r == OP_ADD) begin
        if (can_add) begin
          slot_valid_r[free_idx_r] <= 1'b1;
          add_cnt_r                <= add_cnt_r + STAMP_W'(1);
        end
      end else if (!any_r) begin
        ptr_valid_r <= 1'b0;
      end else begin
        served_level_r <= top_r;
        last_stamp_r   <= sel.stamp;
        ptr_valid_r    <= 1'b1;
        if (!more) begin
          slot_valid_r[sel_idx] <= 1'b0;
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      if (op_r == OP_ADD) begin
        out_status     <= can_add ? STAT_ADDED : STAT_FULL;
        out_run_task   <= '0;
        out_run_length <= '0;
        out_finished   <= 1'b0;
      end else if (!any_r) begin
        out_status     <= STAT_IDLE;
        out_run_task   <= '0;
        out_run_length <= '0;
        out_finished   <= 1'b0;
      end else begin
        out_status     <= STAT_DISPATCHED;
        out_run_task   <= sel.id;
        out_run_length <= more ? q_eff : sel.remaining[RUN_W-1:0];
        out_finished   <= !more;
      end
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

/* rtl/core/priority_round_robin_scheduler.sv */
// Top level of the priority round-robin task scheduler.
`default_nettype none

// Task scheduler with TASK_SLOTS slots. An add item (op 0) stores a task id,
// priority and burst and answers ADDED, or FULL when no slot is free or the
// 16-bit sequence stamp is used up. A dispatch item (op 1) answers one time
// slice: the highest priority level that holds tasks is served, newest task
// first, and the round robin steps to the next older task of that level on
// each dispatch, wrapping to the newest; a slice lasts min(quantum, remaining)
// ticks and a task that finishes is dropped. An empty table answers IDLE.
// Every item is accepted, walks the slot memory one entry per cycle through its
// registered read port and closes the walk; a commit follows to write the slot
// back and load the result register. The next item is accepted as soon as the
// previous one is committed, even if its result still waits on out_if.ready;
// a commit waits while the result register is still full. The quantum register
// (reset 10, zero acts as one) is always ready; the user must write it only
// between items, as the block itself does not enforce this.
module priority_round_robin_scheduler import prrs_pkg::*; #(
  parameter int TASK_SLOTS = 16
) (
  input  wire logic clk,
  input  wire logic rst_n,
  prrs_in_if.sink   in_if,
  prrs_out_if.source out_if,
  prrs_cfg_if.sink  cfg_if
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // configuration is a single register: take every write at once
  assign cfg_if.ready = 1'b1;

  // sequencing of accept, walk and commit
  prrs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_if.ready),
    .cmd      (cmd),
    .stat     (stat)
  );

  // slot table, walk and result register
  prrs_dp #(
    .TASK_SLOTS (TASK_SLOTS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .in_op            (in_if.op),
    .in_task_id       (in_if.task_id),
    .in_task_priority (in_if.task_priority),
    .in_burst_length  (in_if.burst_length),
    .cfg_valid        (cfg_if.valid),
    .cfg_quantum      (cfg_if.quantum),
    .out_valid        (out_if.valid),
    .out_ready        (out_if.ready),
    .out_status       (out_if.status),
    .out_run_task     (out_if.run_task),
    .out_run_length   (out_if.run_length),
    .out_finished     (out_if.finished)
  );

  // an accepted item blocks intake until it is committed
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_if.valid && in_if.ready |=> !in_if.ready)
    else $error("input accepted while an item is in work");

  // only a dispatched slice carries task, length and finish flag
  a_quiet_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && (out_if.status != STAT_DISPATCHED) |->
      (out_if.run_task == '0) && (out_if.run_length == '0) && !out_if.finished)
    else $error("non-dispatch result carries slice fields");

  // an empty slice can only come from a task that ends in it
  a_empty_slice_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && (out_if.status == STAT_DISPATCHED) && (out_if.run_length == '0) |->
      out_if.finished)
    else $error("zero-length slice without finish");

endmodule

`default_nettype wire
